@@ hdl/morse_text_keyer_core_defines.svh @@
// assertion macros used by the checker module
`ifndef MORSE_TEXT_KEYER_CORE_DEFINES_SVH
`define MORSE_TEXT_KEYER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define MTK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be seen outside reset
`define MTK_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ hdl/mtk_pkg.sv @@
// types, constants and code table shared by the morse keyer modules
package mtk_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [2:0] DOT_UNITS         = 3'd1;
    localparam logic [2:0] DASH_UNITS        = 3'd3;
    localparam logic [2:0] ELEMENT_GAP_UNITS = 3'd1;
    localparam logic [2:0] LETTER_GAP_UNITS  = 3'd3;
    localparam logic [2:0] WORD_GAP_UNITS    = 3'd7;
    localparam logic [2:0] HOLD_UNITS        = 3'd0;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'b001,
        KIND_CHAR  = 3'b010,
        KIND_SPACE = 3'b100
    } mtk_kind_t;

    // pattern read left to right from bit 4, 1 is a dash
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } mtk_code_t;

    typedef struct packed {
        logic       has_gap;
        logic       word_gap;
        logic [2:0] len;
        logic [4:0] pat;
        logic       eom;
    } mtk_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mtk_q_status_t;

    localparam mtk_code_t ALPHA_TABLE [26] = '{
        '{3'd2, 5'b01000}, '{3'd4, 5'b10000}, '{3'd4, 5'b10100}, '{3'd3, 5'b10000},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b11000}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b10100}, '{3'd4, 5'b01000},
        '{3'd2, 5'b11000}, '{3'd2, 5'b10000}, '{3'd3, 5'b11100}, '{3'd4, 5'b01100},
        '{3'd4, 5'b11010}, '{3'd3, 5'b01000}, '{3'd3, 5'b00000}, '{3'd1, 5'b10000},
        '{3'd3, 5'b00100}, '{3'd4, 5'b00010}, '{3'd3, 5'b01100}, '{3'd4, 5'b10010},
        '{3'd4, 5'b10110}, '{3'd4, 5'b11000}
    };

    localparam mtk_code_t DIGIT_TABLE [10] = '{
        '{3'd5, 5'b11111}, '{3'd5, 5'b01111}, '{3'd5, 5'b00111}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00001}, '{3'd5, 5'b00000}, '{3'd5, 5'b10000}, '{3'd5, 5'b11000},
        '{3'd5, 5'b11100}, '{3'd5, 5'b11110}
    };

    // zero length means the character is not coded
    function automatic mtk_code_t mtk_lookup(input logic [7:0] ch);
        mtk_code_t code;
        logic [7:0] alpha_off;
        logic [7:0] digit_off;
        code      = '0;
        alpha_off = ch - CH_UPPER_A;
        digit_off = ch - CH_DIGIT_0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            code = ALPHA_TABLE[alpha_off[4:0]];
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            code = DIGIT_TABLE[digit_off[3:0]];
        end
        return code;
    endfunction

endpackage

@@ hdl/mtk_front.sv @@
// input side: classifies characters and queues segment commands
module mtk_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // ch
    input  logic                  s_tlast,    // end_of_message
    input  mtk_pkg::mtk_q_status_t q_status,
    output logic                  push,
    output mtk_pkg::mtk_cmd_t     push_cmd
);
    import mtk_pkg::*;

    mtk_kind_t kind_reg, kind_next;
    mtk_code_t code;
    logic      coded;
    logic      is_space;
    logic      accept;

    always_comb begin
        code     = mtk_lookup(s_tdata);
        coded    = code.len != 3'd0;
        is_space = s_tdata == CH_SPACE;
        accept   = s_tvalid && s_tready;
    end

    assign s_tready = !q_status.full;
    assign push     = accept && (coded || s_tlast);

    always_comb begin
        push_cmd.has_gap  = coded && (kind_reg == KIND_CHAR || kind_reg == KIND_SPACE);
        push_cmd.word_gap = kind_reg == KIND_SPACE;
        push_cmd.len      = code.len;
        push_cmd.pat      = code.pat;
        push_cmd.eom      = s_tlast;
    end

    always_comb begin
        kind_next = kind_reg;
        if (accept) begin
            if (s_tlast) begin
                kind_next = KIND_NONE;
            end else if (coded) begin
                kind_next = KIND_CHAR;
            end else if (is_space) begin
                kind_next = KIND_SPACE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_NONE;
        end else begin
            kind_reg <= kind_next;
        end
    end

endmodule

@@ hdl/mtk_queue.sv @@
// short command queue between the front and back parts
module mtk_queue #(
    parameter int DEPTH = mtk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mtk_pkg::mtk_cmd_t      push_cmd,
    input  logic                   pop,
    output mtk_pkg::mtk_cmd_t      pop_cmd,
    output mtk_pkg::mtk_q_status_t status
);
    import mtk_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    mtk_cmd_t        entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        status.full  = cnt_reg == CntW'(DEPTH);
        status.empty = cnt_reg == '0;
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        pop_cmd      = entry_reg[rd_ptr_reg];
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/mtk_back.sv @@
// output side: expands one command into led segments, one per beat
module mtk_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mtk_pkg::mtk_q_status_t q_status,
    input  mtk_pkg::mtk_cmd_t      q_cmd,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // led_on, duration_units, zero pad
    output logic                   m_tlast    // last_of_run
);
    import mtk_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    logic       gap_pend_reg, gap_pend_next;
    logic       word_gap_reg, word_gap_next;
    logic       sep_pend_reg, sep_pend_next;
    logic [2:0] rem_reg, rem_next;
    logic [4:0] pat_reg, pat_next;
    logic       eom_reg, eom_next;

    logic       out_valid_reg, out_valid_next;
    logic       led_reg;
    logic [2:0] dur_reg;
    logic       last_reg;

    logic       advance;
    logic       seg_led;
    logic [2:0] seg_dur;
    logic       seg_last;
    logic       load;

    always_comb begin
        advance  = cur_valid_reg && (!out_valid_reg || m_tready);
        seg_led  = 1'b0;
        seg_dur  = HOLD_UNITS;
        seg_last = 1'b1;
        if (gap_pend_reg) begin
            seg_dur  = word_gap_reg ? WORD_GAP_UNITS : LETTER_GAP_UNITS;
            seg_last = rem_reg == 3'd0 && !eom_reg;
        end else if (rem_reg != 3'd0) begin
            if (sep_pend_reg) begin
                seg_dur  = ELEMENT_GAP_UNITS;
                seg_last = 1'b0;
            end else begin
                seg_led  = 1'b1;
                seg_dur  = pat_reg[4] ? DASH_UNITS : DOT_UNITS;
                seg_last = rem_reg == 3'd1 && !eom_reg;
            end
        end
        pop  = !cur_valid_reg || (advance && seg_last);
        load = pop && !q_status.empty;
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        gap_pend_next  = gap_pend_reg;
        word_gap_next  = word_gap_reg;
        sep_pend_next  = sep_pend_reg;
        rem_next       = rem_reg;
        pat_next       = pat_reg;
        eom_next       = eom_reg;
        if (advance) begin
            if (gap_pend_reg) begin
                gap_pend_next = 1'b0;
            end else if (rem_reg != 3'd0) begin
                if (sep_pend_reg) begin
                    sep_pend_next = 1'b0;
                end else begin
                    rem_next      = rem_reg - 3'd1;
                    pat_next      = {pat_reg[3:0], 1'b0};
                    sep_pend_next = 1'b1;
                end
            end
            if (seg_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (load) begin
            cur_valid_next = 1'b1;
            gap_pend_next  = q_cmd.has_gap;
            word_gap_next  = q_cmd.word_gap;
            sep_pend_next  = 1'b0;
            rem_next       = q_cmd.len;
            pat_next       = q_cmd.pat;
            eom_next       = q_cmd.eom;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_pend_reg <= gap_pend_next;
        word_gap_reg <= word_gap_next;
        sep_pend_reg <= sep_pend_next;
        rem_reg      <= rem_next;
        pat_reg      <= pat_next;
        eom_reg      <= eom_next;
        if (advance) begin
            led_reg  <= seg_led;
            dur_reg  <= seg_dur;
            last_reg <= seg_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, dur_reg, led_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hdl/morse_text_keyer_core.sv @@
// Morse text keyer: one ASCII character per input beat, one led segment per output beat.
// Letters A-Z and digits 0-9 become dots (1 unit on) and dashes (3 units on) with 1 unit
// off between elements; a coded character is preceded by 3 units off after a character
// or 7 units off after one or more spaces. Other characters produce nothing; tlast on an
// input beat closes the message with an off segment of 0 units and resets the spacing.
// m_tlast marks the last segment caused by an input beat. The back part emits one segment
// per cycle while m_tready is high; a character makes 0 to 11 segments (gap, up to five
// elements with their separators, end mark); the input side accepts a beat every cycle
// until the command queue of QUEUE_DEPTH entries fills, and characters that emit nothing
// never occupy it. Sustained rate is set by the segment count of the characters sent.
module morse_text_keyer_core #(
    parameter int QUEUE_DEPTH = mtk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // led_on, duration_units, zero pad
    output logic       m_tlast    // last_of_run
);
    import mtk_pkg::*;

    mtk_q_status_t q_status;
    mtk_cmd_t      push_cmd;
    mtk_cmd_t      pop_cmd;
    logic          push;
    logic          pop;

    mtk_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mtk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    mtk_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/mtk_checker.sv @@
// port-level checks on the keyer output stream, bound to the top level
`include "morse_text_keyer_core_defines.svh"

module mtk_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       out_led;
    logic [2:0] out_dur;
    logic       on_len_ok;
    logic       hold_seg;
    logic       gap_seg;

    assign out_led   = m_tdata[0];
    assign out_dur   = m_tdata[3:1];
    assign on_len_ok = out_dur == 3'd1 || out_dur == 3'd3;
    assign hold_seg  = out_dur == 3'd0;
    assign gap_seg   = !out_led && !hold_seg;

    `MTK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "beat dropped")
    `MTK_ASSERT(a_on_len, aclk, aresetn, m_tvalid && out_led |-> on_len_ok, "bad on length")
    `MTK_ASSERT(a_hold_last, aclk, aresetn, m_tvalid && hold_seg |-> !out_led && m_tlast, "bad hold")
    `MTK_ASSERT_NEVER(a_gap_last, aclk, aresetn, m_tvalid && gap_seg && m_tlast, "gap ends a run")
    `MTK_ASSERT_NEVER(a_pad_zero, aclk, aresetn, m_tvalid && (|m_tdata[7:4]), "pad not zero")

endmodule

bind morse_text_keyer_core mtk_checker u_mtk_checker (.*);
